[rtl/rpn_stack_calculator_unit_macros.svh]
// ----------------------------------------------------------------------------
// RPN calculator assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_STACK_CALCULATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// RPN calculator package
// Character codes, status codes, operation decode and controller interface.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CH_W   = 8;
	localparam int unsigned STS_W  = 3;

	localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE = 8'h39;
	localparam logic [CH_W-1:0] CH_EQ   = 8'h3D;
	localparam logic [CH_W-1:0] CH_ADD  = 8'h2B;
	localparam logic [CH_W-1:0] CH_SUB  = 8'h2D;
	localparam logic [CH_W-1:0] CH_MUL  = 8'h2A;
	localparam logic [CH_W-1:0] CH_DIV  = 8'h2F;

	localparam logic [STS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STS_W-1:0] ST_OVER       = 3'd1;
	localparam logic [STS_W-1:0] ST_UNDER      = 3'd2;
	localparam logic [STS_W-1:0] ST_DIVZ       = 3'd3;
	localparam logic [STS_W-1:0] ST_UNDER_DIVZ = 3'd4;

	// Value read in place of a missing operand.
	localparam logic [DATA_W-1:0] EMPTY_VAL = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DIGIT,
		OP_EQ,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic accept;
		logic pop;
		logic cap_rhs;
		logic cap_lhs;
		logic exec;
		logic div_load;
		logic push;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic rhs_zero;
		logic div_done;
		logic div_busy;
	} dp_sts_t;

	function automatic op_t decode_op(input logic [CH_W-1:0] ch);
		op_t op;
		unique case (ch) inside
			[CH_ZERO:CH_NINE]: op = OP_DIGIT;
			CH_EQ:             op = OP_EQ;
			CH_ADD:            op = OP_ADD;
			CH_SUB:            op = OP_SUB;
			CH_MUL:            op = OP_MUL;
			CH_DIV:            op = OP_DIV;
			default:           op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

[rtl/rpn_ram.sv]
// ----------------------------------------------------------------------------
// RPN generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/rpn_div.sv]
// ----------------------------------------------------------------------------
// RPN divider
// Iterative radix-2 signed divider, truncating toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module rpn_div
	import rpn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DATA_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;

	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   diff;

	// Shift in the next dividend bit and try a subtraction.
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			rem_q <= '0;
			quo_q <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

[rtl/rpn_dp.sv]
// ----------------------------------------------------------------------------
// RPN datapath
// Operand stack, operand and answer registers, ALU, divider and result word.
// ----------------------------------------------------------------------------
module rpn_dp
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CH_W-1:0]   ch,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	output logic [DATA_W-1:0] value,
	output logic              is_result,
	output logic [STS_W-1:0]  status
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

	logic [CW-1:0]     count_q;
	op_t               op_q;
	logic              over_q;
	logic              under_q;
	logic              divz_q;
	logic              pop_ok_q;
	logic [DATA_W-1:0] rhs_q;
	logic [DATA_W-1:0] lhs_q;
	logic [DATA_W-1:0] ans_q;
	logic [DATA_W-1:0] value_q;
	logic              is_result_q;
	logic [STS_W-1:0]  status_q;

	logic [CW-1:0]     count_dec;
	logic              empty;
	logic              full;
	logic              ram_we;
	logic              ram_re;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] pop_val;
	logic [DATA_W-1:0] product;
	logic [CH_W-1:0]   digit;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic              res_ok;
	logic [STS_W-1:0]  status_d;

	assign count_dec = count_q - 1'b1;
	assign empty     = (count_q == '0);
	assign full      = (count_q == FULL_CNT);
	assign ram_re    = cmd.pop && !empty;
	assign ram_we    = cmd.push && !full;
	assign pop_val   = pop_ok_q ? ram_rdata : EMPTY_VAL;
	assign product   = lhs_q * rhs_q;
	assign digit     = ch - CH_ZERO;
	assign div_start = cmd.exec && (op_q == OP_DIV) && (rhs_q != '0);

	rpn_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(ans_q),
		.re   (ram_re),
		.raddr(count_dec[AW-1:0]),
		.rdata(ram_rdata)
	);

	rpn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(lhs_q),
		.divisor (rhs_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			op_q     <= OP_NONE;
			over_q   <= 1'b0;
			under_q  <= 1'b0;
			divz_q   <= 1'b0;
			pop_ok_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				op_q    <= decode_op(ch);
				over_q  <= 1'b0;
				under_q <= 1'b0;
				divz_q  <= 1'b0;
			end
			if (cmd.pop) begin
				pop_ok_q <= !empty;
				if (empty) begin
					under_q <= 1'b1;
				end else begin
					count_q <= count_dec;
				end
			end
			if (cmd.exec && (op_q == OP_DIV) && (rhs_q == '0)) begin
				divz_q <= 1'b1;
			end
			if (cmd.push) begin
				if (full) begin
					over_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ans_q <= {{(DATA_W - 4){1'b0}}, digit[3:0]};
		end
		if (cmd.cap_rhs) begin
			rhs_q <= pop_val;
		end
		if (cmd.cap_lhs) begin
			lhs_q <= pop_val;
		end
		if (cmd.exec) begin
			case (op_q)
				OP_ADD:  ans_q <= lhs_q + rhs_q;
				OP_SUB:  ans_q <= lhs_q - rhs_q;
				OP_MUL:  ans_q <= product;
				OP_DIV:  ans_q <= '0;
				default: ans_q <= ans_q;
			endcase
		end
		if (cmd.div_load) begin
			ans_q <= div_quo;
		end
		if (cmd.out_load) begin
			value_q     <= res_ok ? rhs_q : '0;
			is_result_q <= res_ok;
			status_q    <= status_d;
		end
	end

	// A result word carries a value only for '=' that found something to pop.
	assign res_ok = (op_q == OP_EQ) && !under_q;

	always_comb begin
		if (over_q) begin
			status_d = ST_OVER;
		end else if (under_q && divz_q) begin
			status_d = ST_UNDER_DIVZ;
		end else if (divz_q) begin
			status_d = ST_DIVZ;
		end else if (under_q) begin
			status_d = ST_UNDER;
		end else begin
			status_d = ST_OK;
		end
	end

	assign sts.rhs_zero = (rhs_q == '0);
	assign sts.div_done = div_done;
	assign sts.div_busy = div_busy;

	assign value     = value_q;
	assign is_result = is_result_q;
	assign status    = status_q;

endmodule

[rtl/rpn_ctrl.sv]
// ----------------------------------------------------------------------------
// RPN controller
// Sequences one character at a time through pops, execution, push and output.
// ----------------------------------------------------------------------------
module rpn_ctrl
	import rpn_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [CH_W-1:0] ch,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  dp_sts_t         sts,
	output dp_cmd_t         cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_POPA = 8'b0000_0010,
		S_POPB = 8'b0000_0100,
		S_POPC = 8'b0000_1000,
		S_EXEC = 8'b0001_0000,
		S_DIVW = 8'b0010_0000,
		S_PUSH = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	op_t    op_q;
	op_t    op_in;
	logic   m_tvalid_q;

	assign op_in = decode_op(ch);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					case (op_in)
						OP_DIGIT: state_d = S_PUSH;
						OP_NONE:  state_d = S_DONE;
						default:  state_d = S_POPA;
					endcase
				end
			end
			S_POPA: begin
				cmd.pop = 1'b1;
				state_d = S_POPB;
			end
			S_POPB: begin
				cmd.cap_rhs = 1'b1;
				if (op_q == OP_EQ) begin
					state_d = S_DONE;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_POPC;
				end
			end
			S_POPC: begin
				cmd.cap_lhs = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (op_q == OP_DIV && !sts.rhs_zero) begin
					state_d = S_DIVW;
				end else begin
					state_d = S_PUSH;
				end
			end
			S_DIVW: begin
				if (sts.div_done) begin
					cmd.div_load = 1'b1;
					state_d      = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_NONE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				op_q <= op_in;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

[rtl/rpn_stack_calculator_unit.sv]
// ----------------------------------------------------------------------------
// RPN stack calculator unit
// Evaluates reverse Polish notation, one ASCII character per input word, on a
// stack of 32-bit signed integers, and returns one result word per character.
//
//   Channel  Direction  Signals                    Contents
//   s_       in         tvalid tready tdata[7:0]   ch
//   m_       out        tvalid tready tdata[31:0]  value
//                                 tuser[3:0]       is_result, status[2:0]
//
// Steps per character, from acceptance to result word loaded: a digit is
// pushed, an ignored character goes straight to output, '=' pops once, '+',
// '-' and '*' pop twice, execute and push, and '/' also waits, except for a
// zero divisor, on the radix-2 divider that retires one quotient bit per cycle.
// Pops read the stack RAM one entry per cycle with registered read data.
// Reset is asynchronous and active low; it empties the stack at once.
// The next character is taken while the previous result word still waits in
// the output register; a stall on the output side holds only the final step.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_unit_macros.svh"

module rpn_stack_calculator_unit
	import rpn_pkg::*;
#(
	parameter int STACK_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// Input word: one character.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CH_W-1:0]   s_tdata,   // [7:0] ch
	// Output word: one result per character.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [31:0] value
	output logic [STS_W:0]    m_tuser    // [0] is_result, [3:1] status
);

	dp_cmd_t           dp_cmd;
	dp_sts_t           dp_sts;
	logic [DATA_W-1:0] value;
	logic              is_result;
	logic [STS_W-1:0]  status;

	// The controller decides the sequence of steps for each character; the
	// datapath owns the stack, the operands and the assembled result word.
	rpn_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.ch      (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (dp_sts),
		.cmd     (dp_cmd)
	);

	rpn_dp #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch       (s_tdata),
		.cmd      (dp_cmd),
		.sts      (dp_sts),
		.value    (value),
		.is_result(is_result),
		.status   (status)
	);

	assign m_tdata = value;
	assign m_tuser = {status, is_result};

	// A popped result always comes with a clean status.
	`RPN_ASSERT_NOW(a_result_ok, m_tvalid && m_tuser[0], m_tuser[3:1] == ST_OK, "result word with bad status")
	// Status codes stay within the defined set.
	`RPN_ASSERT_NOW(a_status_range, m_tvalid, m_tuser[3:1] <= ST_UNDER_DIVZ, "status code out of range")
	// Words that are not results carry a zero value.
	`RPN_ASSERT_NOW(a_value_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "non-result word carries a value")
	// The divider is never running while a new character can be accepted.
	`RPN_ASSERT_NOW(a_idle_div, s_tready, !dp_sts.div_busy, "divider busy while idle")
	// Loading the output register always presents a word next cycle.
	`RPN_ASSERT_NEXT(a_out_load, dp_cmd.out_load, m_tvalid, "loaded result word not presented")

endmodule

[tb/sv/rpn_stack_calculator_unit_test.sv]
// ----------------------------------------------------------------------------
// RPN stack calculator unit testbench
// Sends ASCII characters as input words and checks every result word against
// an in-bench model, or the table for fixed rows. A short table covers the
// empty and full stack, divide by zero and ignored characters. Random
// well-formed expressions follow, mixed with broken sequences and noise. Both
// sides idle in several phases, and one long output stall backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpn_stack_calculator_unit_test;
	import rpn_pkg::*;

	localparam int STACK_DEPTH   = 8;
	localparam int DIRECTED_ROWS = 26;
	localparam int RANDOM_WORDS  = 1824;
	localparam int HOLD_CYCLES   = 400;
	localparam int TAIL_CYCLES   = 80;
	localparam int CYCLE_LIMIT   = 1000000;

	// One result word: value, is_result and status.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              is_result;
		logic [STS_W-1:0]  status;
	} calc_result_t;

	// A row of the directed table. Rows with fixed set carry their expected
	// result. The others are checked against the model.
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            fixed;
		calc_result_t    want;
	} directed_row_t;

	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// Pop from an empty stack.
		'{CH_EQ,          1'b1, '{32'd0, 1'b0, ST_UNDER}},
		// Both operands are missing and read as -1, so -2 is pushed.
		'{CH_ADD,         1'b1, '{32'd0, 1'b0, ST_UNDER}},
		'{CH_EQ,          1'b1, '{32'hFFFF_FFFE, 1'b1, ST_OK}},
		// -1 / -1 from an empty stack pushes 1.
		'{CH_DIV,         1'b1, '{32'd0, 1'b0, ST_UNDER}},
		'{CH_ZERO,        1'b1, '{32'd0, 1'b0, ST_OK}},
		// 1 / 0 pushes 0.
		'{CH_DIV,         1'b1, '{32'd0, 1'b0, ST_DIVZ}},
		// Only the zero is left, so the left operand is missing as well.
		'{CH_DIV,         1'b1, '{32'd0, 1'b0, ST_UNDER_DIVZ}},
		'{CH_EQ,          1'b1, '{32'd0, 1'b1, ST_OK}},
		// Extremes of the character field are ignored.
		'{8'h00,          1'b1, '{32'd0, 1'b0, ST_OK}},
		'{8'hFF,          1'b1, '{32'd0, 1'b0, ST_OK}},
		// Fill the stack, then push one too many.
		'{CH_NINE,        1'b1, '{32'd0, 1'b0, ST_OK}},
		'{CH_ZERO + 8'd8, 1'b1, '{32'd0, 1'b0, ST_OK}},
		'{CH_ZERO + 8'd7, 1'b1, '{32'd0, 1'b0, ST_OK}},
		'{CH_ZERO + 8'd6, 1'b1, '{32'd0, 1'b0, ST_OK}},
		'{CH_ZERO + 8'd5, 1'b1, '{32'd0, 1'b0, ST_OK}},
		'{CH_ZERO + 8'd4, 1'b1, '{32'd0, 1'b0, ST_OK}},
		'{CH_ZERO + 8'd3, 1'b1, '{32'd0, 1'b0, ST_OK}},
		'{CH_ZERO + 8'd2, 1'b1, '{32'd0, 1'b0, ST_OK}},
		'{CH_ZERO + 8'd1, 1'b1, '{32'd0, 1'b0, ST_OVER}},
		// Each operation in turn from the full stack, including a negative quotient.
		'{CH_MUL,         1'b0, '{32'd0, 1'b0, ST_OK}},
		'{CH_SUB,         1'b0, '{32'd0, 1'b0, ST_OK}},
		'{CH_DIV,         1'b0, '{32'd0, 1'b0, ST_OK}},
		'{CH_ADD,         1'b0, '{32'd0, 1'b0, ST_OK}},
		'{CH_EQ,          1'b0, '{32'd0, 1'b0, ST_OK}},
		// Neighbors of the digit and operator codes are ignored too.
		'{CH_NINE + 8'd1, 1'b1, '{32'd0, 1'b0, ST_OK}},
		'{CH_DIV - 8'd1,  1'b1, '{32'd0, 1'b0, ST_OK}}
	};

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [CH_W-1:0]   s_tdata  = '0;   // [7:0] ch
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;         // [31:0] value
	logic [STS_W:0]    m_tuser;         // [0] is_result, [3:1] status

	// Model of the calculator, advanced once per accepted input word.
	logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
	int                calc_depth = 0;
	calc_result_t      pending_results [$];

	int errors         = 0;
	int random_words   = 0;
	int idle_phase     = -1;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	int cycle_count    = 0;

	rpn_stack_calculator_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	function automatic bit is_digit(input logic [CH_W-1:0] ch);
		return ch >= CH_ZERO && ch <= CH_NINE;
	endfunction

	function automatic bit is_operator(input logic [CH_W-1:0] ch);
		return ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV;
	endfunction

	function automatic bit push_value(input logic [DATA_W-1:0] v);
		if (calc_depth < STACK_DEPTH) begin
			calc_stack[calc_depth] = v;
			calc_depth++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// A pop from an empty stack yields -1 and reports the miss.
	function automatic bit pop_value(output logic [DATA_W-1:0] v);
		if (calc_depth > 0) begin
			calc_depth--;
			v = calc_stack[calc_depth];
			return 1'b1;
		end
		v = EMPTY_VAL;
		return 1'b0;
	endfunction

	// Signed division truncated toward zero, done on magnitudes so that the
	// most negative value over -1 wraps back to itself.
	function automatic logic [DATA_W-1:0] quotient_trunc(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] ua;
		logic [DATA_W-1:0] ub;
		logic [DATA_W-1:0] q;
		ua = a[DATA_W-1] ? 32'd0 - a : a;
		ub = b[DATA_W-1] ? 32'd0 - b : b;
		q  = ua / ub;
		return (a[DATA_W-1] != b[DATA_W-1]) ? 32'd0 - q : q;
	endfunction

	function automatic calc_result_t evaluate_char(input logic [CH_W-1:0] ch);
		calc_result_t      r;
		logic [DATA_W-1:0] lhs;
		logic [DATA_W-1:0] rhs;
		logic [DATA_W-1:0] ans;
		bit                under;
		bit                divz;
		r     = '0;
		under = 1'b0;
		divz  = 1'b0;
		if (is_digit(ch)) begin
			if (!push_value(DATA_W'(ch - CH_ZERO)))
				r.status = ST_OVER;
		end else if (ch == CH_EQ) begin
			if (pop_value(rhs)) begin
				r.value     = rhs;
				r.is_result = 1'b1;
			end else begin
				r.status = ST_UNDER;
			end
		end else if (is_operator(ch)) begin
			// Right operand comes off first, then the left one.
			if (!pop_value(rhs))
				under = 1'b1;
			if (!pop_value(lhs))
				under = 1'b1;
			case (ch)
				CH_ADD: ans = lhs + rhs;
				CH_SUB: ans = lhs - rhs;
				CH_MUL: ans = lhs * rhs;
				default: begin
					if (rhs == '0) begin
						divz = 1'b1;
						ans  = '0;
					end else begin
						ans = quotient_trunc(lhs, rhs);
					end
				end
			endcase
			void'(push_value(ans));
			if (under && divz)
				r.status = ST_UNDER_DIVZ;
			else if (divz)
				r.status = ST_DIVZ;
			else if (under)
				r.status = ST_UNDER;
		end
		return r;
	endfunction

	// Offers one character and waits for the handshake. The caller stands
	// just after a rising edge. The handshake is judged at the falling edge,
	// where tvalid and tready are settled until the next rising edge.
	task automatic send_char(input logic [CH_W-1:0] ch, input bit fixed,
			input calc_result_t want);
		calc_result_t predicted;
		bit           taken;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
		predicted = evaluate_char(ch);
		pending_results.push_back(fixed ? want : predicted);
	endtask

	// Random stimulus goes through here; ignored characters do not count.
	task automatic emit(input logic [CH_W-1:0] ch);
		send_char(ch, 1'b0, '0);
		if (is_digit(ch) || is_operator(ch) || ch == CH_EQ)
			random_words++;
	endtask

	function automatic logic [CH_W-1:0] random_digit();
		return CH_ZERO + CH_W'($urandom_range(9));
	endfunction

	// Multiplication is favored so that values grow well past 32 bits.
	function automatic logic [CH_W-1:0] random_op();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return CH_MUL;
		else if (r < 55)
			return CH_ADD;
		else if (r < 75)
			return CH_SUB;
		return CH_DIV;
	endfunction

	// Output side: random stalls, plus one long hold-off on request while the
	// input side keeps offering words.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Result checker, sampled at the falling edge like the input handshake.
	always @(negedge clk) begin
		calc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result word with none expected: value %0d tuser %0h",
					$signed(m_tdata), m_tuser);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.value) begin
					$error("value: expected %0d, got %0d", $signed(want.value),
						$signed(m_tdata));
					errors++;
				end
				if (m_tuser[0] !== want.is_result) begin
					$error("is_result: expected %0d, got %0d", want.is_result, m_tuser[0]);
					errors++;
				end
				if (m_tuser[STS_W:1] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser[STS_W:1]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[rpn_stack_calculator_unit] ERROR");
			$finish;
		end
	end

	initial begin
		int i;
		int kind;
		int left;
		int held;
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++)
			send_char(DIRECTED[i].ch, DIRECTED[i].fixed, DIRECTED[i].want);

		while (random_words < RANDOM_WORDS) begin
			// Idle pattern by quarter: none but the long hold, sender gaps, receiver stalls, both.
			phase = random_words * 4 / RANDOM_WORDS;
			if (phase != idle_phase) begin
				idle_phase = phase;
				case (phase)
					0: begin
						src_idle_pct = 0;
						sink_stall_pct <= 0;
						hold_requests  <= hold_requests + 1;
					end
					1: begin
						src_idle_pct = 81;
						sink_stall_pct <= 0;
					end
					2: begin
						src_idle_pct = 0;
						sink_stall_pct <= 81;
					end
					default: begin
						src_idle_pct = 33;
						sink_stall_pct <= 33;
					end
				endcase
			end

			kind = $urandom_range(99);
			if (kind < 55) begin
				// Well-formed expression, closed by '=' so that the stack returns to its old
				// depth; it fits in the free stack space unless the stack is nearly full.
				left = $urandom_range((calc_depth < STACK_DEPTH - 1) ?
					STACK_DEPTH - calc_depth : 2, 1);
				held = 0;
				while (left > 0 || held > 1) begin
					if (left > 0 && (held < 2 || $urandom_range(1) == 1)) begin
						emit(random_digit());
						left--;
						held++;
					end else begin
						emit(random_op());
						held--;
					end
				end
				emit(CH_EQ);
			end else if (kind < 59) begin
				// Build the most negative value as 8^10 * 2, then divide it by
				// -1, step down to the most positive value, or wrap it again.
				while (calc_depth > 4)
					emit(CH_EQ);
				emit(CH_ZERO + 8'd8);
				repeat (9) begin
					emit(CH_ZERO + 8'd8);
					emit(CH_MUL);
				end
				emit(CH_ZERO + 8'd2);
				emit(CH_MUL);
				case ($urandom_range(2))
					0: begin
						emit(CH_ZERO);
						emit(CH_ZERO + 8'd1);
						emit(CH_SUB);
						emit(CH_DIV);
					end
					1: begin
						emit(CH_ZERO + 8'd1);
						emit(CH_SUB);
					end
					default: begin
						emit(CH_NINE);
						emit(CH_MUL);
					end
				endcase
				emit(CH_EQ);
			end else if (kind < 74) begin
				// Broken sequence: any mix of digits, operators and '='.
				repeat ($urandom_range(6, 1)) begin
					held = $urandom_range(99);
					if (held < 40)
						emit(random_digit());
					else if (held < 60)
						emit(CH_EQ);
					else
						emit(random_op());
				end
			end else if (kind < 84) begin
				repeat ($urandom_range(3, 1))
					emit(CH_W'($urandom_range(255)));
			end else if (kind < 90) begin
				// Flood the stack past full.
				repeat (STACK_DEPTH - calc_depth + $urandom_range(2, 1))
					emit(random_digit());
			end else begin
				// Drain the stack and pop once more from empty.
				repeat (calc_depth + 1)
					emit(CH_EQ);
			end
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[rpn_stack_calculator_unit] OK");
		else
			$display("[rpn_stack_calculator_unit] ERROR");
		$finish;
	end

endmodule

[rpn_stack_calculator_unit.f]
+incdir+rtl
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_div.sv
rtl/rpn_dp.sv
rtl/rpn_ctrl.sv
rtl/rpn_stack_calculator_unit.sv
tb/sv/rpn_stack_calculator_unit_test.sv
